// ----- src/stxd_pkg.sv -----
// ----------------------------------------------------------------------------
// stxd_pkg
// shared types and constants of the stx/length/xor packet deframer
// ----------------------------------------------------------------------------
package stxd_pkg;

  localparam int ByteW  = 8;
  localparam int KindW  = 3;

  localparam logic [ByteW-1:0] STX_BYTE = 8'h02;
  localparam logic [ByteW-1:0] ENQ_BYTE = 8'h05;
  localparam logic [ByteW-1:0] MIN_LEN  = 8'd2;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef enum logic [KindW-1:0] {
    EV_DATA = 3'd0,
    EV_ENQ  = 3'd1,
    EV_OK   = 3'd2,
    EV_CSUM = 3'd3,
    EV_LEN  = 3'd4
  } event_t;

  typedef struct packed {
    event_t           kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] count;
  } result_t;

endpackage

// ----- src/stx_length_xor_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// stx_length_xor_packet_deframer
// byte-wide deframer for stx / length / body / etx / xor-checksum frames
// ----------------------------------------------------------------------------
// One received byte is taken per request on the rx side and gives zero or
// one registered event on the output side. While hunting, enq gives an
// enquiry event and stx opens a frame; other bytes are dropped. The next byte
// is the length L and seeds the xor checksum. The following L-2 bytes come out
// as data byte events, the etx slot after them is only folded into the
// checksum, and the byte after that is compared with it: packet ok (with the
// payload count L-2) or checksum error. A length below 2 gives a length error.
// Throughput is one byte per cycle while in_ready is high: the whole
// decision is a byte compare and an xor in front of the result register.
// A two-entry output buffer (result register plus skid register) lets the
// block keep taking bytes while the consumer stalls, until a second event is
// waiting behind the stalled one; in_ready drops only when both entries are
// full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module stx_length_xor_packet_deframer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [stxd_pkg::ByteW-1:0] rx_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [stxd_pkg::KindW-1:0] event_kind,
  output logic [stxd_pkg::ByteW-1:0] data_byte,
  output logic [stxd_pkg::ByteW-1:0] data_count
);
  import stxd_pkg::*;

  // frame state
  phase_t           phase, phase_next;
  logic [ByteW-1:0] frame_length, frame_length_next;
  logic [ByteW-1:0] byte_index, byte_index_next;
  logic [ByteW-1:0] running_check, running_check_next;

  // result of the byte being accepted
  logic    res_hit;
  result_t res;

  // output register and skid entry
  result_t out_reg;
  result_t skid;
  logic    skid_valid;

  logic accept;
  logic body_last;
  logic [ByteW-1:0] payload_len;

  assign in_ready    = !skid_valid;
  assign accept      = in_valid && in_ready;
  assign payload_len = frame_length - MIN_LEN;
  assign body_last   = (byte_index == payload_len);

  // next state and result of one byte
  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    byte_index_next    = byte_index;
    running_check_next = running_check;
    res_hit            = 1'b0;
    res                = '{kind: EV_DATA, data: '0, count: '0};
    case (phase)
      PH_HUNT: begin
        if (rx_byte == ENQ_BYTE) begin
          res_hit  = 1'b1;
          res.kind = EV_ENQ;
        end else if (rx_byte == STX_BYTE) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (rx_byte < MIN_LEN) begin
          // short length aborts the frame
          phase_next = PH_HUNT;
          res_hit    = 1'b1;
          res.kind   = EV_LEN;
        end else begin
          frame_length_next  = rx_byte;
          running_check_next = rx_byte;
          byte_index_next    = '0;
          phase_next         = PH_BODY;
        end
      end
      PH_BODY: begin
        running_check_next = running_check ^ rx_byte;
        if (body_last) begin
          // etx slot: folded into the checksum only
          phase_next = PH_CHECK;
        end else begin
          byte_index_next = byte_index + 8'd1;
          res_hit         = 1'b1;
          res.kind        = EV_DATA;
          res.data        = rx_byte;
        end
      end
      PH_CHECK: begin
        phase_next = PH_HUNT;
        res_hit    = 1'b1;
        if (rx_byte == running_check) begin
          res.kind  = EV_OK;
          res.count = payload_len;
        end else begin
          res.kind = EV_CSUM;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_length  <= '0;
      byte_index    <= '0;
      running_check <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      byte_index    <= byte_index_next;
      running_check <= running_check_next;
    end
  end

  // output buffer: result register in front, skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        // head drains, skid entry or a fresh result moves up
        out_valid  <= skid_valid || (accept && res_hit);
        skid_valid <= 1'b0;
      end else if (out_valid) begin
        // head stalled, new result parks in the skid entry
        if (accept && res_hit) begin
          skid_valid <= 1'b1;
        end
      end else if (accept && res_hit) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (accept && res_hit) begin
        out_reg <= res;
      end
    end else if (!out_valid && accept && res_hit) begin
      out_reg <= res;
    end
    if (out_valid && !out_ready && accept && res_hit) begin
      skid <= res;
    end
  end

  assign event_kind = out_reg.kind;
  assign data_byte  = out_reg.data;
  assign data_count = out_reg.count;

endmodule

// ----- src/stxd_checker.sv -----
// ----------------------------------------------------------------------------
// stxd_checker
// port-level checks of the deframer output channel
// ----------------------------------------------------------------------------
module stxd_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [stxd_pkg::KindW-1:0] event_kind,
  input logic [stxd_pkg::ByteW-1:0] data_byte,
  input logic [stxd_pkg::ByteW-1:0] data_count
);
  import stxd_pkg::*;

  // stalled request holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
      $stable(data_byte) && $stable(data_count))
    else $error("output request changed while stalled");

  // payload byte only rides on data events
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_DATA |-> data_byte == '0)
    else $error("data byte set on a non-data event");

  // count only rides on packet ok, and never exceeds the largest payload
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind == EV_OK) ? (data_count <= 8'd253) : (data_count == '0))
    else $error("bad data count");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind stx_length_xor_packet_deframer stxd_checker u_stxd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_kind (event_kind),
  .data_byte  (data_byte),
  .data_count (data_count)
);
